FILE: hdl/mte_pkg.sv
// Shared constants, register codes and configuration type for the multi-tap echo delay.
`default_nettype none
package mte_pkg;

	// Default geometry handed to the top level
	localparam int TAP_COUNT_DEF   = 10;
	localparam int LINE_DEPTH_DEF  = 65536;
	localparam int SAMPLE_BITS_DEF = 16;

	// Fixed register field widths
	localparam int GAIN_BITS     = 16;
	localparam int DELAY_BITS    = 13;
	localparam int CFG_ADDR_BITS = 2;
	localparam int CFG_DATA_BITS = 16;

	// Register indexes on the configuration port
	localparam logic [CFG_ADDR_BITS-1:0] REG_ECHO_ENABLE   = 2'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_ECHO_LEVEL    = 2'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DELAY_SAMPLES = 2'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_DECAY_FACTOR  = 2'd3;

	// Reset values of the registers
	localparam logic [GAIN_BITS-1:0]  RST_ECHO_LEVEL    = 16'd32768;
	localparam logic [DELAY_BITS-1:0] RST_DELAY_SAMPLES = 13'd4800;
	localparam logic [GAIN_BITS-1:0]  RST_DECAY_FACTOR  = 16'd32768;

	// Configuration register set
	typedef struct packed {
		logic                  echo_enable;
		logic [GAIN_BITS-1:0]  echo_level;
		logic [DELAY_BITS-1:0] delay_samples;
		logic [GAIN_BITS-1:0]  decay_factor;
	} cfg_t;

endpackage
`default_nettype wire

FILE: hdl/mte_delay_mem.sv
// Synchronous delay line memory: one write port, one registered read port.
`default_nettype none
module mte_delay_mem #(
	parameter int DEPTH = mte_pkg::LINE_DEPTH_DEF,
	parameter int AW    = $clog2(mte_pkg::LINE_DEPTH_DEF),
	parameter int DW    = mte_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write one sample when we is set, read one sample each cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

FILE: hdl/mte_gain_unit.sv
// Tap gain calculator: one shared 16x16 multiplier walks the decay chain into a gain table.
`default_nettype none
module mte_gain_unit #(
	parameter int TAP_COUNT = mte_pkg::TAP_COUNT_DEF,
	parameter int JW        = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mte_pkg::cfg_t                  cfg,
	input  wire logic                           restart,
	output logic                                busy,
	input  wire logic [JW-1:0]                  tap_sel,
	output logic      [mte_pkg::GAIN_BITS-1:0]  tap_gain
);

	localparam int GB = mte_pkg::GAIN_BITS;

	typedef enum logic [2:0] {
		G_LOAD,
		G_MUL_GAIN,
		G_MUL_DECAY,
		G_STEP_D,
		G_IDLE
	} gstate_t;

	gstate_t        state_q;
	logic [JW-1:0]  j_q;
	logic [GB-1:0]  d_q;
	logic [2*GB-1:0] p_q;
	logic [GB-1:0]  gains_q [TAP_COUNT];
	logic [GB-1:0]  mul_a;
	logic [2*GB-1:0] mul_p;
	logic [GB-1:0]  p_round;
	logic           last_tap;

	// Round a Q0.32 product to Q0.16
	function automatic logic [GB-1:0] round_q16(input logic [2*GB-1:0] p);
		logic [2*GB:0] t;
		begin
			t = {1'b0, p} + (2*GB+1)'(1 << (GB - 1));
			return t[2*GB-1:GB];
		end
	endfunction

	// Share one multiplier between level*d and d*d
	always_comb begin
		mul_a = (state_q == G_MUL_GAIN) ? cfg.echo_level : d_q;
		mul_p = mul_a * d_q;
	end

	assign p_round  = round_q16(p_q);
	assign last_tap = (j_q == JW'(TAP_COUNT - 1));
	assign busy     = (state_q != G_IDLE);
	assign tap_gain = gains_q[tap_sel];

	// Sequence state and tap counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_LOAD;
			j_q     <= '0;
		end else if (restart) begin
			state_q <= G_LOAD;
		end else begin
			unique case (state_q)
				G_LOAD: begin
					j_q     <= '0;
					state_q <= G_MUL_GAIN;
				end
				G_MUL_GAIN: begin
					state_q <= G_MUL_DECAY;
				end
				G_MUL_DECAY: begin
					state_q <= last_tap ? G_IDLE : G_STEP_D;
				end
				G_STEP_D: begin
					j_q     <= j_q + JW'(1);
					state_q <= G_MUL_GAIN;
				end
				G_IDLE: begin
					state_q <= G_IDLE;
				end
				default: begin
					state_q <= G_LOAD;
				end
			endcase
		end
	end

	// Decay chain, product and gain table
	always_ff @(posedge clk) begin
		if (state_q == G_LOAD) begin
			d_q <= cfg.decay_factor;
		end
		if (state_q == G_MUL_GAIN || state_q == G_MUL_DECAY) begin
			p_q <= mul_p;
		end
		if (state_q == G_MUL_DECAY) begin
			gains_q[j_q] <= p_round;
		end
		if (state_q == G_STEP_D) begin
			d_q <= p_round;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/mte_tap_engine.sv
// Tap sequencer: reads echo taps from the delay line, weights and sums them, writes back the input.
`default_nettype none
module mte_tap_engine #(
	parameter int TAP_COUNT   = mte_pkg::TAP_COUNT_DEF,
	parameter int LINE_DEPTH  = mte_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = mte_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = $clog2(LINE_DEPTH),
	parameter int JW          = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire mte_pkg::cfg_t                  cfg,
	input  wire logic                           gain_busy,
	output logic      [JW-1:0]                  tap_sel,
	input  wire logic [mte_pkg::GAIN_BITS-1:0]  tap_gain,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample_in,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [SAMPLE_BITS-1:0]         sample_out,
	output logic                                mem_we,
	output logic      [AW-1:0]                  mem_waddr,
	output logic      [SAMPLE_BITS-1:0]         mem_wdata,
	output logic      [AW-1:0]                  mem_raddr,
	input  wire logic [SAMPLE_BITS-1:0]         mem_rdata
);

	localparam int DW        = SAMPLE_BITS;
	localparam int GB        = mte_pkg::GAIN_BITS;
	localparam int DB        = mte_pkg::DELAY_BITS;
	localparam int PW        = DW + GB + 1;
	localparam int ACC_W     = PW + $clog2(TAP_COUNT + 1) + 1;
	localparam int YW        = ACC_W - GB;
	localparam int RW        = (DB > AW + 1) ? DB : AW + 1;
	localparam int RED_STEPS = ((1 << DB) - 1) / LINE_DEPTH;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (GB - 1));
	localparam logic signed [YW-1:0] Y_MAX = $signed({{(YW-DW+1){1'b0}}, {(DW-1){1'b1}}});
	localparam logic signed [YW-1:0] Y_MIN = $signed({{(YW-DW+1){1'b1}}, {(DW-1){1'b0}}});

	typedef enum logic [2:0] {
		E_IDLE,
		E_ADDR,
		E_TAPS,
		E_DRAIN,
		E_FINISH
	} estate_t;

	estate_t                   state_q;
	logic [AW-1:0]             wp_q;
	logic                      wrapped_q;
	logic [AW-1:0]             raddr_q;
	logic [JW-1:0]             j_q;
	logic [AW-1:0]             dred_q;
	logic                      rd_v_s1;
	logic                      tap_ok_s1;
	logic [JW-1:0]             j_s1;
	logic                      mul_v_s2;
	logic signed [PW-1:0]      prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [DW-1:0]      x_q;
	logic [DW-1:0]             out_q;
	logic                      out_valid_q;
	logic [RW-1:0]             dmod;
	logic signed [YW-1:0]      y_full;
	logic [DW-1:0]             y_sat;
	logic                      accept;
	logic                      out_free;
	logic                      finish_go;
	logic signed [DW-1:0]      tap_val;

	// Step an address back by a delay, wrapping round the line
	function automatic logic [AW-1:0] sub_mod(input logic [AW-1:0] a, input logic [AW-1:0] b);
		logic [AW:0] t;
		begin
			t = {1'b0, a} - {1'b0, b};
			if (a < b) begin
				t = t + (AW+1)'(LINE_DEPTH);
			end
			return t[AW-1:0];
		end
	endfunction

	// Reduce the tap spacing modulo the line depth
	always_comb begin
		dmod = RW'(cfg.delay_samples);
		for (int k = 0; k < RED_STEPS; k++) begin
			if (dmod >= RW'(LINE_DEPTH)) begin
				dmod = dmod - RW'(LINE_DEPTH);
			end
		end
	end

	// Round and saturate the accumulated sum
	always_comb begin
		y_full = YW'(acc_q >>> GB);
		if (y_full > Y_MAX) begin
			y_sat = {1'b0, {(DW-1){1'b1}}};
		end else if (y_full < Y_MIN) begin
			y_sat = {1'b1, {(DW-1){1'b0}}};
		end else begin
			y_sat = y_full[DW-1:0];
		end
	end

	assign s_tready   = (state_q == E_IDLE) && !gain_busy;
	assign accept     = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign finish_go  = (state_q == E_FINISH) && out_free;
	assign m_tvalid   = out_valid_q;
	assign sample_out = out_q;
	assign mem_we     = finish_go;
	assign mem_waddr  = wp_q;
	assign mem_wdata  = x_q;
	assign mem_raddr  = raddr_q;
	assign tap_sel    = j_s1;
	assign tap_val    = tap_ok_s1 ? $signed(mem_rdata) : '0;

	// Sequence state, write pointer and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			rd_v_s1     <= 1'b0;
			mul_v_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1  <= (state_q == E_TAPS);
			mul_v_s2 <= rd_v_s1;
			if (finish_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				E_IDLE: begin
					if (accept) begin
						state_q <= E_ADDR;
					end
				end
				E_ADDR: begin
					state_q <= cfg.echo_enable ? E_TAPS : E_FINISH;
				end
				E_TAPS: begin
					if (j_q == JW'(TAP_COUNT - 1)) begin
						state_q <= E_DRAIN;
					end
				end
				E_DRAIN: begin
					if (!rd_v_s1 && !mul_v_s2) begin
						state_q <= E_FINISH;
					end
				end
				E_FINISH: begin
					if (out_free) begin
						state_q <= E_IDLE;
						if (wp_q == AW'(LINE_DEPTH - 1)) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// Address walk, tap pipeline and accumulator
	always_ff @(posedge clk) begin
		dred_q <= dmod[AW-1:0];
		if (accept) begin
			x_q   <= sample_in;
			acc_q <= (ACC_W'(sample_in) <<< GB) + ROUND_HALF;
		end
		if (state_q == E_ADDR) begin
			raddr_q <= sub_mod(wp_q, dred_q);
			j_q     <= '0;
		end
		if (state_q == E_TAPS) begin
			raddr_q <= sub_mod(raddr_q, dred_q);
			j_q     <= j_q + JW'(1);
		end
		// Never-written slots read as zero
		tap_ok_s1 <= wrapped_q || (raddr_q < wp_q);
		j_s1      <= j_q;
		prod_s2   <= $signed({1'b0, tap_gain}) * tap_val;
		if (mul_v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (finish_go) begin
			out_q <= y_sat;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/multitap_echo_delay.sv
// Top level of the multi-tap echo delay: configuration registers and unit wiring.
//
// Usage: one signed audio sample enters per word on the s_ side and one sample leaves
// per word on the m_ side. Each output is the input plus, when echo_enable is set,
// TAP_COUNT echo taps spaced delay_samples apart, weighted by gains that step down
// as the decay factor is squared per tap; the sum saturates to SAMPLE_BITS.
// Each word steps through the address, tap, drain and finish states before the next
// input is taken, the tap state reading one tap per cycle on the single read port of
// the delay line; with echo off the tap and drain states are skipped.
// A finished word waits in the output register; the next input is taken meanwhile,
// and its result holds in the final step until the output register is free.
// Reset clears the write pointer and marks the line empty; slots not yet written read
// as zero. After reset and after each write to echo_level or decay_factor, the gain
// table is rebuilt with s_tready low; s_tready also drops in the cycle of any
// configuration write. Configuration writes are registered; the user must see that they
// are made only while no word is in flight, as the block itself does not enforce it.
`default_nettype none
module multitap_echo_delay #(
	parameter int TAP_COUNT   = mte_pkg::TAP_COUNT_DEF,
	parameter int LINE_DEPTH  = mte_pkg::LINE_DEPTH_DEF,
	parameter int SAMPLE_BITS = mte_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [mte_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
	input  wire logic [mte_pkg::CFG_DATA_BITS-1:0]    cfg_wdata,
	// Input stream
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,  // sample_in
	// Output stream
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata   // sample_out
);

	localparam int AW      = $clog2(LINE_DEPTH);
	localparam int JW      = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	mte_pkg::cfg_t                    cfg_q;
	logic                             restart;
	logic                             gain_busy;
	logic [JW-1:0]                    tap_sel;
	logic [mte_pkg::GAIN_BITS-1:0]    tap_gain;
	logic [SAMPLE_BITS-1:0]           sample_out;
	logic                             mem_we;
	logic [AW-1:0]                    mem_waddr;
	logic [SAMPLE_BITS-1:0]           mem_wdata;
	logic [AW-1:0]                    mem_raddr;
	logic [SAMPLE_BITS-1:0]           mem_rdata;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.echo_enable   <= 1'b0;
			cfg_q.echo_level    <= mte_pkg::RST_ECHO_LEVEL;
			cfg_q.delay_samples <= mte_pkg::RST_DELAY_SAMPLES;
			cfg_q.decay_factor  <= mte_pkg::RST_DECAY_FACTOR;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				mte_pkg::REG_ECHO_ENABLE:   cfg_q.echo_enable   <= cfg_wdata[0];
				mte_pkg::REG_ECHO_LEVEL:    cfg_q.echo_level    <= cfg_wdata;
				mte_pkg::REG_DELAY_SAMPLES: cfg_q.delay_samples <=
					cfg_wdata[mte_pkg::DELAY_BITS-1:0];
				mte_pkg::REG_DECAY_FACTOR:  cfg_q.decay_factor  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Rebuild gains when level or decay changes
	assign restart = cfg_we && (cfg_addr == mte_pkg::REG_ECHO_LEVEL ||
		cfg_addr == mte_pkg::REG_DECAY_FACTOR);

	assign m_tdata = TDATA_W'(sample_out);

	mte_gain_unit #(
		.TAP_COUNT (TAP_COUNT),
		.JW        (JW)
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.restart  (restart),
		.busy     (gain_busy),
		.tap_sel  (tap_sel),
		.tap_gain (tap_gain)
	);

	mte_delay_mem #(
		.DEPTH (LINE_DEPTH),
		.AW    (AW),
		.DW    (SAMPLE_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Close the input while a register write lands
	mte_tap_engine #(
		.TAP_COUNT   (TAP_COUNT),
		.LINE_DEPTH  (LINE_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS),
		.AW          (AW),
		.JW          (JW)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.gain_busy  (gain_busy || cfg_we),
		.tap_sel    (tap_sel),
		.tap_gain   (tap_gain),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.sample_in  (s_tdata[SAMPLE_BITS-1:0]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.sample_out (sample_out),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata)
	);

endmodule
`default_nettype wire

FILE: tb/tb_multitap_echo_delay.sv
// Self-checking testbench for the multi-tap echo delay: directed, random and line-wrap tests.
`timescale 1ns / 100ps
module tb_multitap_echo_delay;

	localparam int TAP_COUNT   = mte_pkg::TAP_COUNT_DEF;
	localparam int LINE_DEPTH  = mte_pkg::LINE_DEPTH_DEF;
	localparam int SAMPLE_BITS = mte_pkg::SAMPLE_BITS_DEF;
	localparam int PTR_BITS    = $clog2(LINE_DEPTH);
	localparam int WORD_BITS   = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam longint SAT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_MIN = -SAT_MAX - 1;
	localparam int RANDOM_WORDS = 640;
	localparam int MAX_REPORTS  = 40;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [mte_pkg::CFG_ADDR_BITS-1:0] reg_code_t;
	typedef logic [mte_pkg::CFG_DATA_BITS-1:0] reg_data_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     cfg_we    = 1'b0;
	reg_code_t                cfg_addr  = mte_pkg::REG_ECHO_ENABLE;
	reg_data_t                cfg_wdata = '0;
	logic                     s_tvalid  = 1'b0;
	logic                     s_tready;
	logic [WORD_BITS-1:0]     s_tdata   = '0;  // sample_in
	logic                     m_tvalid;
	logic                     m_tready  = 1'b0;
	logic [WORD_BITS-1:0]     m_tdata;         // sample_out

	// Echo model state: registers, gain table, delay line and write pointer
	mte_pkg::cfg_t                    echo_cfg;
	bit [mte_pkg::GAIN_BITS-1:0]      tap_gain [TAP_COUNT];
	bit signed [SAMPLE_BITS-1:0]      echo_line [LINE_DEPTH];
	bit [PTR_BITS-1:0]                wr_ptr = '0;

	sample_t expected_out [$];
	int      fail_count = 0;
	bit      tx_gaps    = 1'b1;
	bit      rx_stalls  = 1'b1;

	multitap_echo_delay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	// Rebuild the gain table: the decay factor is squared after every tap
	function automatic void rebuild_gains();
		longint unsigned decay;
		longint unsigned level;
		int j;
		decay = echo_cfg.decay_factor;
		level = echo_cfg.echo_level;
		for (j = 0; j < TAP_COUNT; j++) begin
			tap_gain[j] = mte_pkg::GAIN_BITS'((level * decay + 32768) >> 16);
			decay = (decay * decay + 32768) >> 16;
		end
	endfunction

	// Mix one input sample with its echo taps, then store it in the line
	function automatic sample_t echo_mix(input sample_t dry);
		longint acc;
		longint mixed;
		bit [PTR_BITS-1:0] offset;
		bit [PTR_BITS-1:0] slot;
		int j;
		acc = longint'($signed(dry)) * 65536;
		if (echo_cfg.echo_enable) begin
			for (j = 0; j < TAP_COUNT; j++) begin
				offset = PTR_BITS'(int'(echo_cfg.delay_samples) * (j + 1));
				slot = wr_ptr - offset;
				acc += longint'(tap_gain[j]) * longint'(echo_line[slot]);
			end
		end
		mixed = (acc + 32768) >>> 16;
		if (mixed > SAT_MAX)
			mixed = SAT_MAX;
		else if (mixed < SAT_MIN)
			mixed = SAT_MIN;
		echo_line[wr_ptr] = dry;
		wr_ptr++;
		return sample_t'(mixed);
	endfunction

	// Gap length: mostly short, now and then long
	function automatic int gap_cycles();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 15)
			return $urandom_range(1, 3);
		else if (pick < 19)
			return $urandom_range(4, 12);
		return $urandom_range(20, 48);
	endfunction

	function automatic sample_t pick_sample();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: begin
				case ($urandom_range(0, 3))
					0: return sample_t'(SAT_MAX);
					1: return sample_t'(SAT_MIN);
					2: return '0;
					default: return '1;
				endcase
			end
			1, 2, 3, 4: return sample_t'($urandom);
			default: return sample_t'($urandom_range(0, 8191) - 4096);
		endcase
	endfunction

	function automatic reg_data_t pick_gain();
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: return '0;
			1: return '1;
			2, 3, 4: return mte_pkg::CFG_DATA_BITS'($urandom_range(49152, 65535));
			default: return mte_pkg::CFG_DATA_BITS'($urandom);
		endcase
	endfunction

	// Tap spacing, mostly short so the taps land on written samples; junk in the upper bits
	function automatic reg_data_t pick_delay();
		logic [mte_pkg::DELAY_BITS-1:0] spacing;
		int pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0: spacing = '0;
			1: spacing = mte_pkg::DELAY_BITS'($urandom);
			2: spacing = ($urandom_range(0, 1) != 0) ? '1 : mte_pkg::DELAY_BITS'(6553);
			default: spacing = mte_pkg::DELAY_BITS'($urandom_range(1, 60));
		endcase
		return {(mte_pkg::CFG_DATA_BITS - mte_pkg::DELAY_BITS)'($urandom), spacing};
	endfunction

	// Stop sending and wait for every pending word to come out
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
	endtask

	// Write one register while idle and mirror it in the model
	task automatic write_reg(input reg_code_t code, input reg_data_t value);
		settle();
		// hold off while a gain rebuild keeps the input side closed
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= code;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (code)
			mte_pkg::REG_ECHO_ENABLE: echo_cfg.echo_enable = value[0];
			mte_pkg::REG_ECHO_LEVEL: begin
				echo_cfg.echo_level = value[mte_pkg::GAIN_BITS-1:0];
				rebuild_gains();
			end
			mte_pkg::REG_DELAY_SAMPLES:
				echo_cfg.delay_samples = value[mte_pkg::DELAY_BITS-1:0];
			mte_pkg::REG_DECAY_FACTOR: begin
				echo_cfg.decay_factor = value[mte_pkg::GAIN_BITS-1:0];
				rebuild_gains();
			end
			default: ;
		endcase
		// let a rebuild show up on s_tready before the next idle test
		@(posedge clk);
	endtask

	// Send one word, with an optional gap in front, and queue its expected result
	task automatic send_sample(input sample_t value);
		int gap;
		gap = (tx_gaps && $urandom_range(0, 3) == 0) ? gap_cycles() : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= WORD_BITS'(value);
		do
			@(posedge clk);
		while (!s_tready);
		expected_out.push_back(echo_mix(value));
	endtask

	// Receiver pacing: runs of ready broken by stalls
	initial begin : sink_pacing
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!rx_stalls || $urandom_range(0, 2) != 0) begin
				m_tready <= 1'b1;
				hold = $urandom_range(0, 6);
			end else begin
				m_tready <= 1'b0;
				hold = gap_cycles() - 1;
			end
		end
	end

	// Compare each output word with the oldest expectation
	always @(posedge clk) begin : check_out
		sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_out.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("sample_out: word with no expectation waiting, actual %0d",
						$signed(m_tdata[SAMPLE_BITS-1:0]));
			end else begin
				want = expected_out.pop_front();
				if (m_tdata !== WORD_BITS'(want)) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$error("sample_out mismatch: expected %0d, actual %0d",
							$signed(want), $signed(m_tdata[SAMPLE_BITS-1:0]));
				end
			end
		end
	end

	// Reset configuration passes the dry signal straight through
	task automatic test_dry_path();
		send_sample(sample_t'(SAT_MAX));
		send_sample(sample_t'(SAT_MIN));
		send_sample('0);
		send_sample('1);
		send_sample(sample_t'(1));
	endtask

	// Enable echo on the gains built from the reset registers
	task automatic test_reset_gains();
		write_reg(mte_pkg::REG_ECHO_ENABLE, mte_pkg::CFG_DATA_BITS'(1));
		write_reg(mte_pkg::REG_DELAY_SAMPLES, mte_pkg::CFG_DATA_BITS'(1));
		send_sample(sample_t'(16384));
		send_sample(sample_t'(16384));
		send_sample(sample_t'(-16384));
	endtask

	// Full gains on full-scale input drive the sum into both rails
	task automatic test_saturation();
		int k;
		write_reg(mte_pkg::REG_ECHO_LEVEL, '1);
		write_reg(mte_pkg::REG_DECAY_FACTOR, '1);
		for (k = 0; k < 3; k++)
			send_sample(sample_t'(SAT_MAX));
		for (k = 0; k < 3; k++)
			send_sample(sample_t'(SAT_MIN));
	endtask

	// Zero spacing reads the slot about to be overwritten
	task automatic test_zero_delay();
		write_reg(mte_pkg::REG_DELAY_SAMPLES, '0);
		send_sample(sample_t'(SAT_MAX));
		send_sample(sample_t'(SAT_MIN));
	endtask

	// Widest spacing: later tap offsets wrap round the line; upper data bits dropped
	task automatic test_long_offset();
		write_reg(mte_pkg::REG_DELAY_SAMPLES, '1);
		send_sample(sample_t'(12345));
		send_sample(sample_t'(-12345));
	endtask

	// Zero level and zero decay each silence every tap
	task automatic test_gain_extremes();
		write_reg(mte_pkg::REG_DELAY_SAMPLES, mte_pkg::CFG_DATA_BITS'(1));
		write_reg(mte_pkg::REG_ECHO_LEVEL, '0);
		send_sample(sample_t'(SAT_MAX));
		send_sample(sample_t'(SAT_MIN));
		write_reg(mte_pkg::REG_ECHO_LEVEL, '1);
		write_reg(mte_pkg::REG_DECAY_FACTOR, '0);
		send_sample(sample_t'(SAT_MAX));
		send_sample(sample_t'(SAT_MIN));
	endtask

	// Random settings per phase, random words within each phase
	task automatic test_random_traffic();
		int sent;
		int phase;
		int burst;
		int k;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			write_reg(mte_pkg::REG_ECHO_ENABLE, mte_pkg::CFG_DATA_BITS'($urandom) |
				mte_pkg::CFG_DATA_BITS'($urandom_range(0, 3) != 0));
			write_reg(mte_pkg::REG_ECHO_LEVEL, pick_gain());
			write_reg(mte_pkg::REG_DELAY_SAMPLES, pick_delay());
			write_reg(mte_pkg::REG_DECAY_FACTOR, pick_gain());
			tx_gaps   = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			burst = $urandom_range(30, 90);
			for (k = 0; k < burst; k++) begin
				// drain everything mid-phase now and then
				if (k == burst / 2 && phase % 3 == 0)
					settle();
				send_sample(pick_sample());
			end
			sent += burst;
			phase++;
		end
		tx_gaps   = 1'b1;
		rx_stalls = 1'b1;
	endtask

	// Zero spacing, the widest spacing whose later tap offsets wrap round the line, and one that nearly spans it
	task automatic test_line_wrap();
		reg_data_t spacing [3];
		int k;
		int n;
		spacing = '{mte_pkg::CFG_DATA_BITS'(0), mte_pkg::CFG_DATA_BITS'(8191),
			mte_pkg::CFG_DATA_BITS'(6553)};
		write_reg(mte_pkg::REG_ECHO_ENABLE, mte_pkg::CFG_DATA_BITS'(1));
		write_reg(mte_pkg::REG_ECHO_LEVEL, mte_pkg::CFG_DATA_BITS'(20000));
		write_reg(mte_pkg::REG_DECAY_FACTOR, mte_pkg::CFG_DATA_BITS'(60000));
		for (n = 0; n < 3; n++) begin
			write_reg(mte_pkg::REG_DELAY_SAMPLES, spacing[n]);
			for (k = 0; k < 12; k++)
				send_sample(pick_sample());
		end
	endtask

	initial begin : run
		echo_cfg.echo_enable   = 1'b0;
		echo_cfg.echo_level    = mte_pkg::RST_ECHO_LEVEL;
		echo_cfg.delay_samples = mte_pkg::RST_DELAY_SAMPLES;
		echo_cfg.decay_factor  = mte_pkg::RST_DECAY_FACTOR;
		rebuild_gains();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_dry_path();
		test_reset_gains();
		test_saturation();
		test_zero_delay();
		test_long_offset();
		test_gain_extremes();
		test_random_traffic();
		test_line_wrap();

		settle();
		// watch for stray words after the last one
		repeat (2 * (TAP_COUNT + 6)) @(posedge clk);
		if (expected_out.size() != 0) begin
			$error("sample_out: %0d expected words never arrived", expected_out.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("multitap_echo_delay test passed");
		else
			$display("multitap_echo_delay test failed");
		$finish;
	end

	// Bound the run in case a handshake never completes
	initial begin : watchdog
		#40_000_000;
		$display("multitap_echo_delay test failed");
		$finish;
	end

endmodule
